/* src/bsam_pkg.sv */
// Package for the bit set allocation map: field widths, opcodes and the
// sequencer state type. Depends on nothing; imported by bit_set_allocation_map.
`default_nettype none

package bsam_pkg;

	localparam int OPCODE_W = 3;
	localparam int POS_W    = 12;
	localparam int CFG_W    = 13;
	localparam int POC_W    = 13;

	localparam logic [OPCODE_W-1:0] OP_SET       = 3'd0;
	localparam logic [OPCODE_W-1:0] OP_CLEAR     = 3'd1;
	localparam logic [OPCODE_W-1:0] OP_TEST      = 3'd2;
	localparam logic [OPCODE_W-1:0] OP_FLIP      = 3'd3;
	localparam logic [OPCODE_W-1:0] OP_COUNT     = 3'd4;
	localparam logic [OPCODE_W-1:0] OP_FIND_ZERO = 3'd5;
	localparam logic [OPCODE_W-1:0] OP_FIND_ONE  = 3'd6;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_DIV  = 5'b00010,
		S_RD   = 5'b00100,
		S_EXEC = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

endpackage

`default_nettype wire

/* src/bit_set_allocation_map.sv */
// Bit set allocation map: word-organised bit map with set/clear/test/flip,
// population count and find-first searches. Depends on bsam_pkg.
`default_nettype none

// Channel      Handshake                  Payload
// ------------ -------------------------- ------------------------------------------
// request      in_valid / in_ready        opcode, bit_position
// result       out_valid / out_ready      bit_value, position_or_count, found,
//                                         position_in_range
// size write   cfg_wr_en (no wait)        cfg_wr_data
//
// A count, an unused opcode or an out-of-range bit operation goes from
// acceptance straight to a result on offer. An in-range bit operation first
// finds the word by a reciprocal multiply, then the single memory port does
// a read followed by a write-back (none for a test). A search scans word by
// word: a read, then a lowest-set-bit test on the shared find unit. Reset
// and every size write clear the map at once through one valid flag per
// word; there is no clearing pass. While a result waits for out_ready no
// new transaction is taken.
module bit_set_allocation_map
	import bsam_pkg::*;
#(
	parameter int MAX_BITS  = 4096,
	parameter int WORD_BITS = 64
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [CFG_W-1:0]    cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [OPCODE_W-1:0] opcode,
	input  wire logic [POS_W-1:0]    bit_position,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic                     bit_value,
	output logic [POC_W-1:0]         position_or_count,
	output logic                     found,
	output logic                     position_in_range
);

	// Geometry of the map.
	localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int BIDX_W     = $clog2(WORD_BITS);
	localparam int ACT_W      = $clog2(MAX_BITS + 1);
	localparam int CNT_W      = $clog2(MAX_BITS + 1);
	localparam int LW_RAW     = $clog2(MAX_BITS + WORD_BITS) + 1;
	localparam int LW         = (LW_RAW > POC_W) ? LW_RAW : POC_W;

	// Word index = floor(pos / WORD_BITS) by a multiply with a rounded-up
	// reciprocal; exact for every POS_W-bit position.
	localparam int RECIP_K = POS_W + BIDX_W;
	localparam int PROD_W  = POS_W + RECIP_K + 1;
	localparam logic [RECIP_K:0] RECIP_M =
		(RECIP_K+1)'(((2 ** RECIP_K) + WORD_BITS - 1) / WORD_BITS);

	state_t state_q;

	logic [OPCODE_W-1:0]   op_q;
	logic [POS_W-1:0]      pos_q;
	logic [WADDR_W-1:0]    addr_q;
	logic [BIDX_W-1:0]     bidx_q;
	logic [LW-1:0]         base_q;
	logic [ACT_W-1:0]      active_q;
	logic [CNT_W-1:0]      ones_q;
	logic [WORD_COUNT-1:0] word_vld_q;

	logic [WORD_BITS-1:0]  map_mem [WORD_COUNT];
	logic [WORD_BITS-1:0]  rdata_q;
	logic                  rvld_q;

	logic                  bit_value_q;
	logic [POC_W-1:0]      poc_q;
	logic                  found_q;
	logic                  in_range_q;

	logic                  in_fire;
	logic                  is_bitop;
	logic                  is_search;
	logic [LW-1:0]         pos_ext;
	logic [LW-1:0]         active_ext;
	logic [LW-1:0]         cfg_ext;
	logic [PROD_W-1:0]     recip_prod;
	logic [LW-1:0]         bidx_full;
	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  bit_mask;
	logic [WORD_BITS-1:0]  new_word;
	logic                  old_bit;
	logic                  word_write;
	logic [WORD_BITS-1:0]  scan_bits;
	logic [WORD_BITS-1:0]  lowest;
	logic [BIDX_W-1:0]     lowest_idx;
	logic                  scan_hit;
	logic [LW-1:0]         hit_pos;
	logic [LW-1:0]         ones_ext;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_DONE);
	assign in_fire   = in_valid && in_ready;

	assign is_bitop  = (op_q == OP_SET) || (op_q == OP_CLEAR) ||
	                   (op_q == OP_TEST) || (op_q == OP_FLIP);
	assign is_search = (op_q == OP_FIND_ZERO) || (op_q == OP_FIND_ONE);

	assign pos_ext    = LW'(bit_position);
	assign active_ext = LW'(active_q);
	assign cfg_ext    = LW'(cfg_wr_data);
	assign ones_ext   = LW'(ones_q);

	assign recip_prod = PROD_W'(pos_q) * PROD_W'(RECIP_M);
	assign bidx_full  = LW'(pos_q) - LW'(addr_q) * LW'(WORD_BITS);

	// A word that has not been written since the last clear reads as zero.
	assign word     = rvld_q ? rdata_q : '0;
	assign bit_mask = WORD_BITS'(1) << bidx_q;
	assign old_bit  = word[bidx_q];

	always_comb begin
		case (op_q)
			OP_SET:   new_word = word | bit_mask;
			OP_CLEAR: new_word = word & ~bit_mask;
			OP_FLIP:  new_word = word ^ bit_mask;
			default:  new_word = word;
		endcase
	end

	assign word_write = (state_q == S_EXEC) && is_bitop && (op_q != OP_TEST);

	// Shared find unit: isolate the lowest set bit, then encode its index.
	assign scan_bits = (op_q == OP_FIND_ONE) ? word : ~word;
	assign lowest    = scan_bits & (~scan_bits + WORD_BITS'(1));
	assign scan_hit  = |scan_bits;

	always_comb begin
		lowest_idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (lowest[i]) begin
				lowest_idx = lowest_idx | BIDX_W'(i);
			end
		end
	end

	assign hit_pos = base_q + LW'(lowest_idx);

	// Map storage: one read and at most one write per cycle.
	always_ff @(posedge clk) begin
		rdata_q <= map_mem[addr_q];
		if (word_write) begin
			map_mem[addr_q] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			rvld_q     <= 1'b0;
		end else begin
			rvld_q <= word_vld_q[addr_q];
			if (cfg_wr_en) begin
				word_vld_q <= '0;
			end else if (word_write) begin
				word_vld_q[addr_q] <= 1'b1;
			end
		end
	end

	// Sequencer and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			active_q <= '0;
			ones_q   <= '0;
		end else begin
			if (cfg_wr_en) begin
				active_q <= (cfg_ext > LW'(MAX_BITS)) ? ACT_W'(MAX_BITS)
				                                      : ACT_W'(cfg_wr_data);
				ones_q   <= '0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if ((opcode == OP_SET) || (opcode == OP_CLEAR) ||
						    (opcode == OP_TEST) || (opcode == OP_FLIP)) begin
							state_q <= (pos_ext < active_ext) ? S_DIV : S_DONE;
						end else if ((opcode == OP_FIND_ZERO) ||
						             (opcode == OP_FIND_ONE)) begin
							state_q <= S_RD;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DIV: begin
					state_q <= S_RD;
				end
				S_RD: begin
					if (is_search && (base_q >= active_ext)) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (is_bitop) begin
						if ((op_q == OP_SET) && !old_bit) begin
							ones_q <= ones_q + CNT_W'(1);
						end else if ((op_q == OP_CLEAR) && old_bit) begin
							ones_q <= ones_q - CNT_W'(1);
						end else if (op_q == OP_FLIP) begin
							ones_q <= old_bit ? ones_q - CNT_W'(1) : ones_q + CNT_W'(1);
						end
						state_q <= S_DONE;
					end else if (scan_hit) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_RD;
					end
				end
				S_DONE: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers and the result register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					op_q        <= opcode;
					pos_q       <= bit_position;
					addr_q      <= '0;
					base_q      <= '0;
					bit_value_q <= 1'b0;
					found_q     <= 1'b0;
					in_range_q  <= ((opcode == OP_SET) || (opcode == OP_CLEAR) ||
					                (opcode == OP_TEST) || (opcode == OP_FLIP)) &&
					               (pos_ext < active_ext);
					poc_q       <= (opcode == OP_COUNT) ? ones_ext[POC_W-1:0] : '0;
				end
			end
			S_DIV: begin
				addr_q <= recip_prod[RECIP_K +: WADDR_W];
			end
			S_RD: begin
				bidx_q <= bidx_full[BIDX_W-1:0];
			end
			S_EXEC: begin
				if (is_bitop) begin
					if (op_q == OP_TEST) begin
						bit_value_q <= old_bit;
					end
				end else if (scan_hit) begin
					// A hit in padding above the active size counts as a miss.
					if (hit_pos < active_ext) begin
						found_q <= 1'b1;
						poc_q   <= hit_pos[POC_W-1:0];
					end
				end else begin
					addr_q <= addr_q + WADDR_W'(1);
					base_q <= base_q + LW'(WORD_BITS);
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign bit_value         = bit_value_q;
	assign position_or_count = poc_q;
	assign found             = found_q;
	assign position_in_range = in_range_q;

endmodule

`default_nettype wire
